>>> hw/rtl/tracking_filter_2d_assert.svh
// Assertion macros shared by the tracking filter RTL.
`ifndef TRACKING_FILTER_2D_ASSERT_SVH
`define TRACKING_FILTER_2D_ASSERT_SVH

// Immediate implication checked at each clock edge outside reset.
`define TF2D_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tracking filter check failed");

// Implication whose consequence is checked at the next clock edge.
`define TF2D_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tracking filter check failed");

`endif

>>> hw/rtl/tf2d_pkg.sv
// Shared types, codes and saturating arithmetic for the tracking filter.
package tf2d_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int VALUE_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS  = 24;
  localparam int PROD_WIDTH      = 2 * VALUE_WIDTH;

  localparam logic [2:0] STEP_VDT  = 3'd0;
  localparam logic [2:0] STEP_ADT  = 3'd1;
  localparam logic [2:0] STEP_HALF = 3'd2;
  localparam logic [2:0] STEP_RES  = 3'd3;
  localparam logic [2:0] STEP_PG   = 3'd4;
  localparam logic [2:0] STEP_RG   = 3'd5;
  localparam logic [2:0] STEP_AG   = 3'd6;

  localparam logic OPC_LOAD = 1'b0;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic       acc_en;
    logic [2:0] step;
    logic       axis;
  } cmd_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] time_step;
    logic [24:0] position_gain;
    logic [31:0] rate_gain;
    logic [31:0] accel_gain;
  } cfg_t;

  function automatic value_t sat_add(value_t a, value_t b);
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
      return s[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    return s[VALUE_WIDTH-1:0];
  endfunction

  function automatic value_t sat_sub(value_t a, value_t b);
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
      return s[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    return s[VALUE_WIDTH-1:0];
  endfunction

endpackage

>>> hw/rtl/tracking_filter_2d.sv
// Top level of the two-axis alpha-beta / alpha-beta-gamma tracking filter.
// A load transaction can hand over its result in the cycle after acceptance. A measurement runs
// each axis through one shared 32x32 multiplier (a multiply and an accumulate state per product,
// only an accumulate state for the residual); gamma mode adds the acceleration steps.
// One item is in flight at a time; the next is accepted the cycle after the result is taken.
// Synchronous active-high reset clears the state to zero and loads register defaults.
module tracking_filter_2d (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // x_value, y_value, x_rate_init, y_rate_init (from bit 0)
  input  logic [127:0] s_tdata,
  // opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // x_position, x_velocity, x_accel, y_position, y_velocity, y_accel (from bit 0)
  output logic [191:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tf2d_pkg::*;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_DT    = 3'd1;
  localparam logic [2:0] REG_ALPHA = 3'd2;
  localparam logic [2:0] REG_BETA  = 3'd3;
  localparam logic [2:0] REG_GAMMA = 3'd4;

  cfg_t   cfg;
  cmd_t   cmd;
  value_t out_pos [2];
  value_t out_vel [2];
  value_t out_acc [2];
  logic   cfg_write;

  // Configuration registers; the user must change these only while the block is idle (not enforced here).
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= 1'b0;
      cfg.time_step     <= 32'd65536;
      cfg.position_gain <= 25'd14260634;
      cfg.rate_gain     <= 32'd83886;
      cfg.accel_gain    <= 32'd493;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_MODE:  cfg.mode          <= pwdata[0];
        REG_DT:    cfg.time_step     <= pwdata;
        REG_ALPHA: cfg.position_gain <= pwdata[24:0];
        REG_BETA:  cfg.rate_gain     <= pwdata;
        REG_GAMMA: cfg.accel_gain    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:  prdata = {31'd0, cfg.mode};
      REG_DT:    prdata = cfg.time_step;
      REG_ALPHA: prdata = {7'd0, cfg.position_gain};
      REG_BETA:  prdata = cfg.rate_gain;
      REG_GAMMA: prdata = cfg.accel_gain;
      default:   prdata = '0;
    endcase
  end

  // The controller owns the handshake; the datapath does all the arithmetic.
  tf2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_opcode (s_tuser),
    .mode      (cfg.mode),
    .out_ready (m_tready),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  tf2d_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_opcode (s_tuser),
    .in_x      (s_tdata[31:0]),
    .in_y      (s_tdata[63:32]),
    .in_xr     (s_tdata[95:64]),
    .in_yr     (s_tdata[127:96]),
    .out_pos   (out_pos),
    .out_vel   (out_vel),
    .out_acc   (out_acc)
  );

  // The result is read straight from the state registers, which hold still
  // while the transaction waits on the output side.
  assign m_tdata = {out_acc[1], out_vel[1], out_pos[1], out_acc[0], out_vel[0], out_pos[0]};

  `include "tracking_filter_2d_assert.svh"

  `TF2D_ASSERT_NOW(a_one_side, clk, rst, m_tvalid, !s_tready)
  `TF2D_ASSERT_NEXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready)
  `TF2D_ASSERT_NEXT(a_out_held, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

>>> hw/rtl/tf2d_ctrl.sv
// Sequencer that steps the shared multiplier through the filter update.
module tf2d_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_opcode,
  input  logic          mode,
  input  logic          out_ready,
  output logic          in_ready,
  output logic          out_valid,
  output tf2d_pkg::cmd_t cmd
);
  import tf2d_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] step, step_next;
  logic       axis, axis_next;
  logic [2:0] succ;
  logic       last;

  always_comb begin
    succ = STEP_RES;
    last = 1'b0;
    unique case (step)
      STEP_VDT:  succ = mode ? STEP_ADT : STEP_RES;
      STEP_ADT:  succ = STEP_HALF;
      STEP_HALF: succ = STEP_RES;
      STEP_RES:  succ = STEP_PG;
      STEP_PG:   succ = STEP_RG;
      STEP_RG:   begin
        succ = STEP_AG;
        last = !mode;
      end
      STEP_AG:   last = 1'b1;
      default:   last = 1'b1;
    endcase
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    axis_next   = axis;
    cmd         = '0;
    cmd.step    = step;
    cmd.axis    = axis;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_next   = STEP_VDT;
          axis_next   = 1'b0;
          state_next  = (in_opcode == OPC_LOAD) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (last) begin
          if (!axis) begin
            axis_next  = 1'b1;
            step_next  = STEP_VDT;
            state_next = ST_MUL;
          end else begin
            state_next = ST_OUT;
          end
        end else begin
          step_next  = succ;
          state_next = (succ == STEP_RES) ? ST_ACC : ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_VDT;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      axis  <= axis_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

endmodule

>>> hw/rtl/tf2d_dp.sv
// Datapath: state registers, shared multiplier and saturating accumulate.
module tf2d_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  tf2d_pkg::cmd_t        cmd,
  input  tf2d_pkg::cfg_t        cfg,
  input  logic                  in_opcode,
  input  tf2d_pkg::value_t      in_x,
  input  tf2d_pkg::value_t      in_y,
  input  tf2d_pkg::value_t      in_xr,
  input  tf2d_pkg::value_t      in_yr,
  output tf2d_pkg::value_t      out_pos [2],
  output tf2d_pkg::value_t      out_vel [2],
  output tf2d_pkg::value_t      out_acc [2]
);
  import tf2d_pkg::*;

  value_t pos [2];
  value_t vel [2];
  value_t acc [2];
  value_t meas [2];
  value_t pp, vp, adt, res;
  logic   show_acc;

  logic [PROD_WIDTH-1:0] prod;
  logic                  prod_neg;
  logic [5:0]            prod_sh;

  value_t                opa;
  logic [VALUE_WIDTH-1:0] opg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [5:0]            sh;

  logic [PROD_WIDTH:0]   rnd;
  logic [VALUE_WIDTH-1:0] lim, mval;
  value_t                term;

  always_comb begin
    opa = res;
    opg = cfg.time_step;
    sh  = 6'(VALUE_FRAC_BITS);
    case (cmd.step)
      STEP_VDT:  opa = vel[cmd.axis];
      STEP_ADT:  opa = acc[cmd.axis];
      STEP_HALF: begin
        opa = adt;
        sh  = 6'(VALUE_FRAC_BITS + 1);
      end
      STEP_PG: begin
        opg = VALUE_WIDTH'(cfg.position_gain);
        sh  = 6'(GAIN_FRAC_BITS);
      end
      STEP_RG: begin
        opg = cfg.rate_gain;
        sh  = 6'(GAIN_FRAC_BITS);
      end
      STEP_AG: begin
        opg = cfg.accel_gain;
        sh  = 6'(GAIN_FRAC_BITS);
      end
      default: ;
    endcase
    mag = opa[VALUE_WIDTH-1] ? (~opa + 1'b1) : opa;
  end

  // Round half away from zero on the magnitude, then clamp and restore sign.
  always_comb begin
    rnd  = ({1'b0, prod} + ((PROD_WIDTH+1)'(1) << (prod_sh - 6'd1))) >> prod_sh;
    lim  = prod_neg ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    if (rnd[PROD_WIDTH:VALUE_WIDTH] != '0 || rnd[VALUE_WIDTH-1:0] > lim)
      mval = lim;
    else
      mval = rnd[VALUE_WIDTH-1:0];
    term = prod_neg ? value_t'(~mval + 1'b1) : value_t'(mval);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= PROD_WIDTH'(mag) * PROD_WIDTH'(opg);
      prod_neg <= opa[VALUE_WIDTH-1];
      prod_sh  <= sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '{default: '0};
      vel      <= '{default: '0};
      acc      <= '{default: '0};
      show_acc <= 1'b0;
    end else if (cmd.capture) begin
      meas[0] <= in_x;
      meas[1] <= in_y;
      if (in_opcode == OPC_LOAD) begin
        pos[0]   <= in_x;
        pos[1]   <= in_y;
        vel[0]   <= in_xr;
        vel[1]   <= in_yr;
        acc      <= '{default: '0};
        show_acc <= 1'b1;
      end else begin
        show_acc <= cfg.mode;
      end
    end else if (cmd.acc_en) begin
      case (cmd.step)
        STEP_VDT: begin
          pp <= sat_add(pos[cmd.axis], term);
          vp <= vel[cmd.axis];
        end
        STEP_ADT: begin
          adt <= term;
          vp  <= sat_add(vel[cmd.axis], term);
        end
        STEP_HALF: pp <= sat_add(pp, term);
        STEP_RES:  res <= sat_sub(meas[cmd.axis], pp);
        STEP_PG:   pos[cmd.axis] <= sat_add(pp, term);
        STEP_RG:   vel[cmd.axis] <= sat_add(vp, term);
        STEP_AG:   acc[cmd.axis] <= sat_add(acc[cmd.axis], term);
        default: ;
      endcase
    end
  end

  assign out_pos = pos;
  assign out_vel = vel;
  assign out_acc[0] = show_acc ? acc[0] : '0;
  assign out_acc[1] = show_acc ? acc[1] : '0;

endmodule
